/* sv/bdrb_pkg.sv */
// shared types and constants of the burst drop ring buffer
// no dependencies; used by every module of the block
package bdrb_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int MAX_BURST  = 1024;
  localparam int MAX_READ   = 64;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int PTR_W  = IDX_W + 1;
  localparam int LEN_W  = 11;
  localparam int RMAX_W = 7;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = CQ_AW + 1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_AW + 1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] sample_bits;
    logic              first_of_burst;
    logic [LEN_W-1:0]  burst_len;
    logic              last_of_burst;
    logic [RMAX_W-1:0] read_max;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_sample;
    logic              is_empty;
    logic              last_of_run;
    logic              resynced;
    logic [CNT_W-1:0]  drop_count;
  } out_t;

  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] sample;
    logic              first;
    logic [LEN_W-1:0]  len;
    logic              oversize;
    logic              last;
    logic [RMAX_W-1:0] rmax;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } bk_state_t;

endpackage

/* sv/bdrb_front.sv */
// front end: accepts items, normalizes burst length and read size,
// and queues the resulting commands for the back end; uses bdrb_pkg
module bdrb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  bdrb_pkg::in_t  in_item,
  output logic           cmd_vld,
  input  logic           cmd_rdy,
  output bdrb_pkg::cmd_t cmd
);

  bdrb_pkg::cmd_t                   cls;
  bdrb_pkg::cmd_t                   q_r [bdrb_pkg::CQ_DEPTH];
  logic [bdrb_pkg::CQ_AW-1:0]       wp_r, wp_nxt;
  logic [bdrb_pkg::CQ_AW-1:0]       rp_r, rp_nxt;
  logic [bdrb_pkg::CQ_CW-1:0]       cnt_r, cnt_nxt;
  logic                             wr, rd;

  always_comb begin
    cls.is_read = in_item.mode;
    cls.sample  = in_item.sample_bits;
    cls.first   = in_item.first_of_burst;
    cls.last    = in_item.last_of_burst;
    if (in_item.burst_len == '0) begin
      cls.len = bdrb_pkg::LEN_W'(1);
    end else begin
      cls.len = in_item.burst_len;
    end
    cls.oversize = (cls.len > bdrb_pkg::LEN_W'(bdrb_pkg::MAX_BURST));
    priority if (in_item.read_max == '0) begin
      cls.rmax = bdrb_pkg::RMAX_W'(1);
    end else if (in_item.read_max > bdrb_pkg::RMAX_W'(bdrb_pkg::MAX_READ)) begin
      cls.rmax = bdrb_pkg::RMAX_W'(bdrb_pkg::MAX_READ);
    end else begin
      cls.rmax = in_item.read_max;
    end
  end

  assign full    = (cnt_r == bdrb_pkg::CQ_CW'(bdrb_pkg::CQ_DEPTH));
  assign cmd_vld = (cnt_r != '0);
  assign cmd     = q_r[rp_r];
  assign wr      = push && !full;
  assign rd      = cmd_vld && cmd_rdy;

  always_comb begin
    wp_nxt  = wr ? wp_r + bdrb_pkg::CQ_AW'(1) : wp_r;
    rp_nxt  = rd ? rp_r + bdrb_pkg::CQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + bdrb_pkg::CQ_CW'(wr) - bdrb_pkg::CQ_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

/* sv/bdrb_back.sv */
// back end: ring memory, burst admission, drop counting and read sequencing
// uses bdrb_pkg; feeds bdrb_out_queue through a registered memory read
module bdrb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_vld,
  output logic                       cmd_rdy,
  input  bdrb_pkg::cmd_t             cmd,
  input  logic [bdrb_pkg::OQ_CW-1:0] oq_cnt,
  output logic                       oq_push,
  output bdrb_pkg::out_t             oq_data
);

  localparam int PW = bdrb_pkg::PTR_W;
  localparam int RW = bdrb_pkg::RMAX_W;

  logic [bdrb_pkg::DATA_W-1:0] mem [bdrb_pkg::RING_DEPTH];

  bdrb_pkg::bk_state_t state_r, state_nxt;

  logic [PW-1:0]                 head_r, tail_r, bp_r;
  logic                          adm_r, pend_r;
  logic [bdrb_pkg::CNT_W-1:0]    total_r;

  logic [bdrb_pkg::IDX_W-1:0]    rd_ptr_r;
  logic [RW-1:0]                 rd_left_r;
  logic                          rd_empty_r, rd_resync_r;
  logic [bdrb_pkg::CNT_W-1:0]    rd_drop_r;

  logic                          slot_vld_r, slot_empty_r, slot_last_r, slot_resync_r;
  logic [bdrb_pkg::CNT_W-1:0]    slot_drop_r;
  logic [bdrb_pkg::DATA_W-1:0]   mem_q_r;

  logic                          do_wr, do_rd, issue, issue_ok, issue_last;

  logic [PW-1:0]                 used, space, bp_eff, bp_new, tail_eff, avail;
  logic                          fits, drop, adm, room, store, rd_none;
  logic [bdrb_pkg::CNT_W:0]      sum;
  logic [bdrb_pkg::CNT_W-1:0]    total_sat;
  logic [RW-1:0]                 n;

  assign issue_ok   = ((oq_cnt + bdrb_pkg::OQ_CW'(slot_vld_r))
                       < bdrb_pkg::OQ_CW'(bdrb_pkg::OQ_DEPTH));
  assign issue_last = (rd_left_r == RW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdrb_pkg::ST_IDLE: begin
        if (cmd_vld && cmd.is_read) begin
          state_nxt = bdrb_pkg::ST_READ;
        end
      end
      bdrb_pkg::ST_READ: begin
        if (issue_ok && issue_last) begin
          state_nxt = bdrb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bdrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_rdy = 1'b0;
    do_wr   = 1'b0;
    do_rd   = 1'b0;
    issue   = 1'b0;
    unique case (state_r)
      bdrb_pkg::ST_IDLE: begin
        cmd_rdy = cmd_vld;
        do_wr   = cmd_vld && !cmd.is_read;
        do_rd   = cmd_vld && cmd.is_read;
      end
      bdrb_pkg::ST_READ: begin
        issue = issue_ok;
      end
      default: ;
    endcase
  end

  // write admission and read setup
  always_comb begin
    used      = head_r - tail_r;
    space     = PW'(bdrb_pkg::RING_DEPTH) - used;
    fits      = !cmd.oversize && (PW'(cmd.len) <= space);
    drop      = cmd.first && !fits;
    adm       = cmd.first ? fits : adm_r;
    bp_eff    = cmd.first ? head_r : bp_r;
    room      = ((bp_eff - tail_r) < PW'(bdrb_pkg::RING_DEPTH));
    store     = adm && room;
    bp_new    = store ? bp_eff + PW'(1) : bp_eff;
    sum       = {1'b0, total_r} + (bdrb_pkg::CNT_W + 1)'(cmd.len);
    total_sat = sum[bdrb_pkg::CNT_W] ? '1 : sum[bdrb_pkg::CNT_W-1:0];

    tail_eff  = pend_r ? head_r : tail_r;
    avail     = head_r - tail_eff;
    rd_none   = (avail == '0);
    n         = (avail < PW'(cmd.rmax)) ? RW'(avail) : cmd.rmax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bdrb_pkg::ST_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      bp_r       <= '0;
      adm_r      <= 1'b0;
      pend_r     <= 1'b0;
      total_r    <= '0;
      slot_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      slot_vld_r <= issue;
      if (do_wr) begin
        bp_r  <= bp_new;
        adm_r <= adm && !cmd.last;
        if (adm && cmd.last) begin
          head_r <= bp_new;
        end
        if (drop) begin
          total_r <= total_sat;
          pend_r  <= 1'b1;
        end
      end
      if (do_rd) begin
        pend_r <= 1'b0;
        tail_r <= tail_eff + PW'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      rd_ptr_r    <= tail_eff[bdrb_pkg::IDX_W-1:0];
      rd_left_r   <= rd_none ? RW'(1) : n;
      rd_empty_r  <= rd_none;
      rd_resync_r <= pend_r;
      rd_drop_r   <= total_r;
    end else if (issue) begin
      rd_ptr_r  <= rd_ptr_r + bdrb_pkg::IDX_W'(1);
      rd_left_r <= rd_left_r - RW'(1);
    end
    if (issue) begin
      slot_empty_r  <= rd_empty_r;
      slot_last_r   <= issue_last;
      slot_resync_r <= rd_resync_r;
      slot_drop_r   <= rd_drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr && store) begin
      mem[bp_eff[bdrb_pkg::IDX_W-1:0]] <= cmd.sample;
    end
    if (issue) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  assign oq_push             = slot_vld_r;
  assign oq_data.out_sample  = slot_empty_r ? '0 : mem_q_r;
  assign oq_data.is_empty    = slot_empty_r;
  assign oq_data.last_of_run = slot_last_r;
  assign oq_data.resynced    = slot_resync_r;
  assign oq_data.drop_count  = slot_drop_r;

endmodule

/* sv/bdrb_out_queue.sv */
// result queue between the back end and the result ports
// uses bdrb_pkg; reports its fill level so the back end can reserve space
module bdrb_out_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  bdrb_pkg::out_t             wr_data,
  output logic [bdrb_pkg::OQ_CW-1:0] cnt,
  output logic                       empty,
  input  logic                       pop,
  output bdrb_pkg::out_t             out_item
);

  bdrb_pkg::out_t               q_r [bdrb_pkg::OQ_DEPTH];
  logic [bdrb_pkg::OQ_AW-1:0]   wp_r, wp_nxt;
  logic [bdrb_pkg::OQ_AW-1:0]   rp_r, rp_nxt;
  logic [bdrb_pkg::OQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                         rd;

  assign empty    = (cnt_r == '0);
  assign cnt      = cnt_r;
  assign out_item = q_r[rp_r];
  assign rd       = pop && !empty;

  always_comb begin
    wp_nxt  = wr ? wp_r + bdrb_pkg::OQ_AW'(1) : wp_r;
    rp_nxt  = rd ? rp_r + bdrb_pkg::OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + bdrb_pkg::OQ_CW'(wr) - bdrb_pkg::OQ_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= wr_data;
    end
  end

endmodule

/* sv/burst_drop_ring_buffer_top.sv */
// top level of the burst drop ring buffer: front end, back end, result queue
// uses bdrb_pkg, bdrb_front, bdrb_back and bdrb_out_queue
//
// Sample ring of 4096 words fed in bursts; a burst that does not fit is
// dropped whole and counted. Items pass through a 4-entry command queue to
// the back end, which handles one command at a time: a write is stored or
// dropped directly; a read request is set up, then issues its results (1 to
// 64) one by one via the single read port of the ring memory. Results leave
// through a 4-entry queue; while a read waits there for room, up to four
// further items are still accepted into the command queue before full
// rises. No clearing pass after reset.
module burst_drop_ring_buffer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  bdrb_pkg::in_t  in_item,
  output logic           empty,
  input  logic           pop,
  output bdrb_pkg::out_t out_item
);

  logic                       cmd_vld, cmd_rdy;
  bdrb_pkg::cmd_t             cmd;
  logic [bdrb_pkg::OQ_CW-1:0] oq_cnt;
  logic                       oq_push;
  bdrb_pkg::out_t             oq_data;

  bdrb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cmd_vld (cmd_vld),
    .cmd_rdy (cmd_rdy),
    .cmd     (cmd)
  );

  bdrb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (cmd_vld),
    .cmd_rdy (cmd_rdy),
    .cmd     (cmd),
    .oq_cnt  (oq_cnt),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  bdrb_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (oq_push),
    .wr_data  (oq_data),
    .cnt      (oq_cnt),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // result queue never takes a transfer beyond its depth
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt < bdrb_pkg::OQ_CW'(bdrb_pkg::OQ_DEPTH)))
    else $error("result queue overflow");

  // back end takes a command only when one is there
  a_cmd_taken_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_rdy |-> cmd_vld)
    else $error("command taken from empty queue");

  // an empty result closes its read and carries no sample
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_data.is_empty) |->
      (oq_data.last_of_run && (oq_data.out_sample == '0)))
    else $error("malformed empty result");

endmodule

/* tb/sv/bdrb_result_checker.sv */
// result checker for the burst drop ring buffer: predicts every read from the
// accepted items and compares each result transfer field by field
// depends on bdrb_pkg for the item types and the ring sizes
module bdrb_result_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           full,
  input  bdrb_pkg::in_t  in_item,
  input  logic           empty,
  input  logic           pop,
  input  bdrb_pkg::out_t out_item,
  output int             fail_count,
  output int             due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bdrb_pkg::PTR_W-1:0] ptr_t;

  logic [bdrb_pkg::DATA_W-1:0] ring_copy [bdrb_pkg::RING_DEPTH];
  ptr_t                        commit_ptr;
  ptr_t                        fill_ptr;
  ptr_t                        tail_ptr;
  bit                          burst_open;
  logic [bdrb_pkg::CNT_W-1:0]  drops;
  bit                          resync_due;
  bdrb_pkg::out_t              due_results [$];

  function automatic void predict_write(bdrb_pkg::in_t it);
    int unsigned len;
    int unsigned space;
    ptr_t        used;
    if (it.first_of_burst) begin
      len = (it.burst_len == 0) ? 1 : it.burst_len;
      used = commit_ptr - tail_ptr;
      space = bdrb_pkg::RING_DEPTH - used;
      fill_ptr = commit_ptr;
      if (len > bdrb_pkg::MAX_BURST || len > space) begin
        burst_open = 0;
        drops = (drops > {bdrb_pkg::CNT_W{1'b1}} - len) ? {bdrb_pkg::CNT_W{1'b1}}
                                                          : drops + len;
        resync_due = 1;
        return;
      end
      burst_open = 1;
    end
    if (!burst_open) return;
    used = fill_ptr - tail_ptr;
    if (used < bdrb_pkg::RING_DEPTH) begin
      ring_copy[fill_ptr[bdrb_pkg::IDX_W-1:0]] = it.sample_bits;
      fill_ptr = fill_ptr + 1'b1;
    end
    if (it.last_of_burst) begin
      commit_ptr = fill_ptr;
      burst_open = 0;
    end
  endfunction

  function automatic void predict_read(logic [bdrb_pkg::RMAX_W-1:0] rmax);
    int unsigned    n;
    ptr_t           avail;
    ptr_t           rd;
    bdrb_pkg::out_t r;
    n = (rmax == 0) ? 1 : (rmax > bdrb_pkg::MAX_READ) ? bdrb_pkg::MAX_READ : rmax;
    r.resynced = resync_due;
    if (resync_due) begin
      resync_due = 0;
      tail_ptr = commit_ptr;
    end
    r.drop_count = drops;
    avail = commit_ptr - tail_ptr;
    if (avail == 0) begin
      r.out_sample = '0;
      r.is_empty = 1'b1;
      r.last_of_run = 1'b1;
      due_results.push_back(r);
      return;
    end
    if (avail < n) n = avail;
    r.is_empty = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      rd = tail_ptr + ptr_t'(i);
      r.out_sample = ring_copy[rd[bdrb_pkg::IDX_W-1:0]];
      r.last_of_run = (i + 1 == n);
      due_results.push_back(r);
    end
    tail_ptr = tail_ptr + ptr_t'(n);
  endfunction

  function automatic void check_field(string name, logic [bdrb_pkg::DATA_W-1:0] want,
                                      logic [bdrb_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    bdrb_pkg::out_t want;
    if (!rst_n) begin
      commit_ptr = '0;
      fill_ptr = '0;
      tail_ptr = '0;
      burst_open = 0;
      drops = '0;
      resync_due = 0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: out_sample %0h",
                 out_item.out_sample);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("out_sample", want.out_sample, out_item.out_sample);
          check_field("is_empty", want.is_empty, out_item.is_empty);
          check_field("last_of_run", want.last_of_run, out_item.last_of_run);
          check_field("resynced", want.resynced, out_item.resynced);
          check_field("drop_count", want.drop_count, out_item.drop_count);
        end
      end
      if (push && !full) begin
        if (in_item.mode) predict_read(in_item.read_max);
        else predict_write(in_item);
      end
    end
    due_count = due_results.size();
  end

endmodule

/* tb/sv/burst_drop_ring_buffer_top_tb.sv */
// testbench top for the burst drop ring buffer: clock, reset, item stimulus,
// random result back-pressure and the verdict
// depends on bdrb_pkg, burst_drop_ring_buffer_top and bdrb_result_checker
module burst_drop_ring_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_READ    = 1'b1;
  localparam int   RANDOM_ITEMS = 250;
  localparam int   QUIET_ITEMS  = 40;
  localparam int   CYCLE_LIMIT  = 1_000_000;

  logic           clk;
  logic           rst_n;
  logic           push;
  logic           full;
  bdrb_pkg::in_t  in_item;
  logic           empty;
  logic           pop;
  bdrb_pkg::out_t out_item;
  int             fail_count;
  int             due_count;
  bit             idling_on = 1;
  int             items_sent;
  int             cycles;

  burst_drop_ring_buffer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  bdrb_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever @(negedge clk) begin
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (idling_on && stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic bdrb_pkg::in_t write_item(logic [bdrb_pkg::DATA_W-1:0] bits, bit first,
                                               logic [bdrb_pkg::LEN_W-1:0] len, bit last);
    bdrb_pkg::in_t it;
    it.mode = MODE_WRITE;
    it.sample_bits = bits;
    it.first_of_burst = first;
    it.burst_len = first ? len : bdrb_pkg::LEN_W'($urandom);
    it.last_of_burst = last;
    it.read_max = bdrb_pkg::RMAX_W'($urandom);
    return it;
  endfunction

  function automatic bdrb_pkg::in_t read_item(logic [bdrb_pkg::RMAX_W-1:0] rmax);
    bdrb_pkg::in_t it;
    it.mode = MODE_READ;
    it.sample_bits = $urandom;
    it.first_of_burst = 1'($urandom);
    it.burst_len = bdrb_pkg::LEN_W'($urandom);
    it.last_of_burst = 1'($urandom);
    it.read_max = rmax;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(bdrb_pkg::in_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_burst(int declared, int count, bit close);
    for (int i = 0; i < count; i++) begin
      send(write_item($urandom, i == 0, bdrb_pkg::LEN_W'(declared),
                      close && i == count - 1));
    end
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    do @(negedge clk); while (due_count != 0);
  endtask

  initial begin
    int          rand_base;
    int          pick;
    int          len;
    bit          paused_once;
    logic [63:0] raw;
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    items_sent = 0;
    paused_once = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty read, zero length, clamps, drops, abandoned and long bursts
    send(read_item(bdrb_pkg::RMAX_W'(0)));
    send(write_item('1, 1'b1, bdrb_pkg::LEN_W'(0), 1'b1));
    send(write_item('0, 1'b1, bdrb_pkg::LEN_W'(3), 1'b0));
    send(write_item(32'hA5A5_5A5A, 1'b0, bdrb_pkg::LEN_W'(0), 1'b0));
    send(write_item(32'h8000_0001, 1'b0, bdrb_pkg::LEN_W'(0), 1'b1));
    send(read_item(bdrb_pkg::RMAX_W'(127)));
    send(read_item(bdrb_pkg::RMAX_W'(64)));
    send(write_item($urandom, 1'b1, bdrb_pkg::LEN_W'(2047), 1'b0));
    send(write_item($urandom, 1'b0, bdrb_pkg::LEN_W'(0), 1'b1));
    send(read_item(bdrb_pkg::RMAX_W'(1)));
    send(write_item($urandom, 1'b1, bdrb_pkg::LEN_W'(4), 1'b0));
    send(write_item($urandom, 1'b0, bdrb_pkg::LEN_W'(0), 1'b0));
    send(write_item($urandom, 1'b1, bdrb_pkg::LEN_W'(1), 1'b1));
    write_burst(2, 4, 1'b1);
    send(read_item(bdrb_pkg::RMAX_W'(2)));
    send(read_item(bdrb_pkg::RMAX_W'(64)));
    send(read_item(bdrb_pkg::RMAX_W'(1)));
    hold_until_drained();

    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (items_sent - rand_base >= RANDOM_ITEMS - QUIET_ITEMS) idling_on <= 0;
      if (!paused_once && items_sent - rand_base >= RANDOM_ITEMS / 2) begin
        paused_once = 1;
        hold_until_drained();
      end
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) write_burst(0, 1, 1'b1);
        else write_burst(len, len, 1'b1);
      end else if (pick < 75) begin
        if ($urandom_range(0, 5) == 0) begin
          send(read_item(bdrb_pkg::RMAX_W'($urandom_range(0, 127))));
        end else begin
          send(read_item(bdrb_pkg::RMAX_W'($urandom_range(1, 16))));
        end
      end else if (pick < 82) begin
        write_burst($urandom_range(bdrb_pkg::MAX_BURST + 1, 2047), $urandom_range(1, 3),
                    1'b1);
      end else if (pick < 94) begin
        write_burst($urandom_range(1, 8), $urandom_range(1, 12), 1'($urandom_range(0, 1)));
      end else begin
        raw = {$urandom, $urandom};
        send(bdrb_pkg::in_t'(raw[$bits(bdrb_pkg::in_t)-1:0]));
      end
    end

    push <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
